// ===== hdl/wft_pkg.sv =====
// Shared types, codes and helpers for the word frequency table unit.
package wft_pkg;

	// Input item: one command per transfer
	typedef struct packed {
		logic       func;
		logic [7:0] ch;
	} item_t;

	// Result item: one per completed word
	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  slot;
		logic [15:0] word_count;
		logic [4:0]  word_length;
	} result_t;

	// Command codes
	localparam logic FUNC_CHAR  = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_MATCH  = 2'd0;
	localparam logic [1:0] ST_INSERT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	// Table walker states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_CMP
	} bk_state_t;

	// ASCII letter test: A-Z or a-z
	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

endpackage

// ===== hdl/wft_front.sv =====
// Front end: assembles the pending word and hands finished words and clears to the queue.
module wft_front #(
	parameter int MAX_WORD_LEN = 19
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      accept,
	input  wft_pkg::item_t                            item,
	output logic                                      push,
	output logic                                      push_clear,
	output logic [$clog2(MAX_WORD_LEN+1)-1:0]         push_len,
	output logic [MAX_WORD_LEN-1:0][7:0]              push_bytes
);
	import wft_pkg::*;

	localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);

	logic [MAX_WORD_LEN-1:0][7:0] pend_bytes_q;
	logic [LEN_W-1:0]             pend_len_q;
	logic                         letter;
	logic                         room;
	logic                         do_clear;
	logic                         do_append;
	logic                         do_finish;

	// Classify the accepted item
	always_comb begin
		letter    = is_letter(item.ch);
		room      = pend_len_q < LEN_W'(MAX_WORD_LEN);
		do_clear  = accept && (item.func == FUNC_CLEAR);
		do_append = accept && (item.func == FUNC_CHAR) && letter && room;
		do_finish = accept && (item.func == FUNC_CHAR) && !(letter && room)
		            && (pend_len_q != '0);
	end

	// Queue push: a finished word or a clear, in arrival order
	assign push       = do_clear || do_finish;
	assign push_clear = do_clear;
	assign push_len   = pend_len_q;
	assign push_bytes = pend_bytes_q;

	// Pending word; bytes past the length are kept zero so rows compare whole
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_len_q   <= '0;
			pend_bytes_q <= '0;
		end else if (do_clear || do_finish) begin
			pend_len_q   <= '0;
			pend_bytes_q <= '0;
		end else if (do_append) begin
			pend_len_q <= pend_len_q + LEN_W'(1);
			for (int i = 0; i < MAX_WORD_LEN; i++) begin
				if (pend_len_q == LEN_W'(i)) begin
					pend_bytes_q[i] <= item.ch;
				end
			end
		end
	end

endmodule

// ===== hdl/wft_queue.sv =====
// Two-entry queue between the front end and the table walker.
module wft_queue #(
	parameter int WIDTH = 161
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty,
	output logic             full
);
	logic [WIDTH-1:0] data_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign dout  = data_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= din;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/wft_back.sv =====
// Back end: walks entries per word, updates counts, inserts or reports full; clears.
module wft_back #(
	parameter int ENTRIES      = 32,
	parameter int MAX_WORD_LEN = 19,
	parameter int COUNT_BITS   = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  logic                              q_clear,
	input  logic [$clog2(MAX_WORD_LEN+1)-1:0] q_len,
	input  logic [MAX_WORD_LEN-1:0][7:0]      q_bytes,
	output logic                              pop,
	output logic                              done,
	output wft_pkg::result_t                  result
);
	import wft_pkg::*;

	localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int USED_W = $clog2(ENTRIES + 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	// Table storage
	logic [MAX_WORD_LEN-1:0][7:0] row_mem [ENTRIES];
	logic [LEN_W-1:0]             len_mem [ENTRIES];
	logic [COUNT_BITS-1:0]        cnt_mem [ENTRIES];

	logic [MAX_WORD_LEN-1:0][7:0] rd_row_q;
	logic [LEN_W-1:0]             rd_len_q;
	logic [COUNT_BITS-1:0]        rd_cnt_q;

	bk_state_t                    state_q;
	bk_state_t                    state_d;
	logic [USED_W-1:0]            used_q;
	logic [USED_W-1:0]            idx_q;
	logic [MAX_WORD_LEN-1:0][7:0] wbytes_q;
	logic [LEN_W-1:0]             wlen_q;
	logic                         done_q;
	result_t                      result_q;

	logic                         hit;
	logic                         at_end;
	logic [COUNT_BITS-1:0]        cnt_new;
	logic                         ld_word;
	logic                         do_clear;
	logic                         idx_inc;
	logic                         ins_wr;
	logic                         cnt_we;
	logic [IDX_W-1:0]             cnt_waddr;
	logic [COUNT_BITS-1:0]        cnt_wdata;
	logic                         emit;
	result_t                      res_d;

	assign hit     = (rd_len_q == wlen_q) && (rd_row_q == wbytes_q);
	assign at_end  = (idx_q == used_q);
	assign cnt_new = (rd_cnt_q == CNT_MAX) ? rd_cnt_q : rd_cnt_q + COUNT_BITS'(1);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && !q_clear) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				state_d = at_end ? BK_IDLE : BK_CMP;
			end
			BK_CMP: begin
				state_d = hit ? BK_IDLE : BK_SCAN;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Per-state controls and result
	always_comb begin
		pop      = 1'b0;
		ld_word  = 1'b0;
		do_clear = 1'b0;
		idx_inc  = 1'b0;
		ins_wr   = 1'b0;
		cnt_we   = 1'b0;
		emit     = 1'b0;
		res_d    = '0;
		cnt_waddr = idx_q[IDX_W-1:0];
		cnt_wdata = cnt_new;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					if (q_clear) begin
						do_clear = 1'b1;
					end else begin
						ld_word = 1'b1;
					end
				end
			end
			BK_SCAN: begin
				// No stored entry matched: insert or report full
				if (at_end) begin
					emit              = 1'b1;
					res_d.word_length = 5'(wlen_q);
					if (used_q < USED_W'(ENTRIES)) begin
						ins_wr           = 1'b1;
						cnt_we           = 1'b1;
						cnt_waddr        = used_q[IDX_W-1:0];
						cnt_wdata        = COUNT_BITS'(1);
						res_d.status     = ST_INSERT;
						res_d.slot       = 5'(used_q);
						res_d.word_count = 16'(1);
					end else begin
						res_d.status = ST_FULL;
					end
				end
			end
			BK_CMP: begin
				if (hit) begin
					cnt_we            = 1'b1;
					emit              = 1'b1;
					res_d.status      = ST_MATCH;
					res_d.slot        = 5'(idx_q);
					res_d.word_count  = 16'(cnt_new);
					res_d.word_length = 5'(wlen_q);
				end else begin
					idx_inc = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			used_q  <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (do_clear) begin
				used_q <= '0;
			end else if (ins_wr) begin
				used_q <= used_q + USED_W'(1);
			end
			if (ld_word) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + USED_W'(1);
			end
		end
	end

	// Word under test and result register
	always_ff @(posedge clk) begin
		if (ld_word) begin
			wbytes_q <= q_bytes;
			wlen_q   <= q_len;
		end
		if (emit) begin
			result_q <= res_d;
		end
	end

	// Table memories: one write port each, registered read at the walk index
	always_ff @(posedge clk) begin
		if (ins_wr) begin
			row_mem[used_q[IDX_W-1:0]] <= wbytes_q;
			len_mem[used_q[IDX_W-1:0]] <= wlen_q;
		end
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		rd_row_q <= row_mem[idx_q[IDX_W-1:0]];
		rd_len_q <= len_mem[idx_q[IDX_W-1:0]];
		rd_cnt_q <= cnt_mem[idx_q[IDX_W-1:0]];
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== hdl/word_frequency_table_unit.sv =====
// Top level of the word frequency table unit.
//
// Characters arrive one per transfer (start high while busy is low). A letter
// is appended to the pending word; any other byte, or a letter hitting a full
// word, finishes the word and queues it. The table walker then compares the
// word with stored entries in slot order (registered memory read, then a
// whole-row compare, for each entry) and finally matches, inserts or reports
// full. done is high for exactly one cycle with the result on result and
// cannot be held off. Two finished words or clears can wait in the queue;
// busy is high while that queue is full. A clear empties the pending word at
// once and the table in turn with queued words. No clearing pass after reset
// is needed.
module word_frequency_table_unit #(
	parameter int ENTRIES      = 32,
	parameter int MAX_WORD_LEN = 19,
	parameter int COUNT_BITS   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  wft_pkg::item_t   item,
	output logic             done,
	output wft_pkg::result_t result
);
	import wft_pkg::*;

	localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
	localparam int Q_W   = 1 + LEN_W + 8 * MAX_WORD_LEN;

	logic                         accept;
	logic                         push;
	logic                         push_clear;
	logic [LEN_W-1:0]             push_len;
	logic [MAX_WORD_LEN-1:0][7:0] push_bytes;
	logic [Q_W-1:0]               q_din;
	logic [Q_W-1:0]               q_dout;
	logic                         q_empty;
	logic                         q_full;
	logic                         pop;
	logic                         q_clear;
	logic [LEN_W-1:0]             q_len;
	logic [MAX_WORD_LEN-1:0][7:0] q_bytes;

	assign busy   = q_full;
	assign accept = start && !busy;

	wft_front #(
		.MAX_WORD_LEN(MAX_WORD_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.push      (push),
		.push_clear(push_clear),
		.push_len  (push_len),
		.push_bytes(push_bytes)
	);

	assign q_din = {push_clear, push_len, push_bytes};

	wft_queue #(
		.WIDTH(Q_W)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (q_din),
		.pop   (pop),
		.dout  (q_dout),
		.empty (q_empty),
		.full  (q_full)
	);

	assign {q_clear, q_len, q_bytes} = q_dout;

	wft_back #(
		.ENTRIES     (ENTRIES),
		.MAX_WORD_LEN(MAX_WORD_LEN),
		.COUNT_BITS  (COUNT_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_clear(q_clear),
		.q_len  (q_len),
		.q_bytes(q_bytes),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

	// Checks
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("queue push while full");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty) else $error("queue pop while empty");

	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("results on consecutive cycles");

	a_full_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_FULL)) |->
		(result.slot == '0) && (result.word_count == '0) && (result.word_length != '0))
		else $error("table-full result fields wrong");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the word frequency table unit.
`timescale 1ns / 100ps

module tb;
	import wft_pkg::*;

	localparam int N_ENTRIES    = 32;
	localparam int WORD_MAX     = 19;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam int RANDOM_ITEMS = 1200;
	// one word walk with a full table, times the queue depth and margin
	localparam int TAIL_CYCLES  = 4 * (2 * N_ENTRIES + 2);
	localparam int WATCHDOG     = 4000;

	// Directed stimulus row; the expected result is typed in where obvious
	typedef struct packed {
		logic       func;
		logic [7:0] ch;
		logic [4:0] reps;
		logic       typed;
		result_t    want;
	} stim_row_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    done;
	result_t result;

	// typed expectation that travels with the item being offered
	logic    typed_on;
	result_t typed_want;

	// predictor state: stored words, their counts and the word being built
	logic [7:0]  tbl_chars [N_ENTRIES][WORD_MAX];
	int          tbl_len   [N_ENTRIES];
	logic [15:0] tbl_cnt   [N_ENTRIES];
	int          tbl_used;
	logic [7:0]  word_chars [WORD_MAX];
	int          word_len;

	result_t expected_words [$];

	// vocabulary of random words, so that repeats and matches happen
	logic [7:0] vocab [24][WORD_MAX];
	int         vocab_len [24];

	int  err_cnt;
	int  idle_cycles;
	int  chars_taken;
	int  n_match, n_insert, n_full;
	bit  gaps_on;

	stim_row_t dir_rows [21] = '{
		'{FUNC_CLEAR, 8'hFF, 5'd1,  1'b0, '0},
		'{FUNC_CHAR,  8'h20, 5'd1,  1'b0, '0},
		'{FUNC_CHAR,  8'h41, 5'd1,  1'b0, '0},
		'{FUNC_CHAR,  8'h00, 5'd1,  1'b1, '{ST_INSERT, 5'd0, 16'd1, 5'd1}},
		'{FUNC_CHAR,  8'h61, 5'd1,  1'b0, '0},
		'{FUNC_CHAR,  8'hFF, 5'd1,  1'b1, '{ST_INSERT, 5'd1, 16'd1, 5'd1}},
		'{FUNC_CHAR,  8'h41, 5'd1,  1'b0, '0},
		'{FUNC_CHAR,  8'h40, 5'd1,  1'b1, '{ST_MATCH, 5'd0, 16'd2, 5'd1}},
		'{FUNC_CHAR,  8'h5A, 5'd1,  1'b0, '0},
		'{FUNC_CHAR,  8'h7A, 5'd1,  1'b0, '0},
		'{FUNC_CHAR,  8'h5B, 5'd1,  1'b1, '{ST_INSERT, 5'd2, 16'd1, 5'd2}},
		'{FUNC_CHAR,  8'h60, 5'd1,  1'b0, '0},
		'{FUNC_CHAR,  8'h7B, 5'd1,  1'b0, '0},
		'{FUNC_CHAR,  8'h71, 5'd19, 1'b0, '0},
		'{FUNC_CHAR,  8'h51, 5'd1,  1'b1, '{ST_INSERT, 5'd3, 16'd1, 5'd19}},
		'{FUNC_CHAR,  8'h80, 5'd1,  1'b0, '0},
		'{FUNC_CHAR,  8'h62, 5'd2,  1'b0, '0},
		'{FUNC_CLEAR, 8'h00, 5'd1,  1'b0, '0},
		'{FUNC_CHAR,  8'h2E, 5'd1,  1'b0, '0},
		'{FUNC_CHAR,  8'h7A, 5'd1,  1'b0, '0},
		'{FUNC_CHAR,  8'h7F, 5'd1,  1'b1, '{ST_INSERT, 5'd0, 16'd1, 5'd1}}
	};

	word_frequency_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always #1 clk = ~clk;

	function automatic bit alpha(input logic [7:0] c);
		logic [7:0] lc;
		lc = c | 8'h20;
		return (lc >= 8'h61) && (lc <= 8'h7A);
	endfunction

	function automatic logic [7:0] any_letter();
		int k;
		k = $urandom_range(0, 51);
		return (k < 26) ? 8'(8'h41 + k) : 8'(8'h61 + k - 26);
	endfunction

	function automatic logic [7:0] any_separator();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (alpha(b));
		return b;
	endfunction

	task automatic flag_mismatch(input string msg);
		err_cnt++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Look the finished word up, count it or store it, and empty it
	task automatic close_word(output result_t res);
		int  i, k;
		bit  same, hit;
		hit = 1'b0;
		res = '{ST_FULL, 5'd0, 16'd0, 5'(word_len)};
		for (i = 0; i < tbl_used && !hit; i++) begin
			same = (tbl_len[i] == word_len);
			for (k = 0; k < word_len && same; k++)
				same = (tbl_chars[i][k] == word_chars[k]);
			if (same) begin
				hit = 1'b1;
				if (tbl_cnt[i] != COUNT_MAX)
					tbl_cnt[i]++;
				res = '{ST_MATCH, 5'(i), tbl_cnt[i], 5'(word_len)};
			end
		end
		if (!hit && tbl_used < N_ENTRIES) begin
			for (k = 0; k < word_len; k++)
				tbl_chars[tbl_used][k] = word_chars[k];
			tbl_len[tbl_used] = word_len;
			tbl_cnt[tbl_used] = 16'd1;
			res = '{ST_INSERT, 5'(tbl_used), 16'd1, 5'(word_len)};
			tbl_used++;
		end
		word_len = 0;
	endtask

	// Predict the effect of one accepted item
	task automatic word_table_step(input item_t it, output bit made, output result_t res);
		made = 1'b0;
		res  = '0;
		if (it.func == FUNC_CLEAR) begin
			tbl_used = 0;
			word_len = 0;
		end else if (alpha(it.ch)) begin
			if (word_len < WORD_MAX) begin
				word_chars[word_len] = it.ch;
				word_len++;
			end else begin
				// letter on a full word ends it and is lost
				close_word(res);
				made = 1'b1;
			end
		end else if (word_len != 0) begin
			close_word(res);
			made = 1'b1;
		end
	endtask

	// Offer one item and wait for its transfer
	task automatic send(input logic f, input logic [7:0] c, input logic tv, input result_t tw);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		start      <= 1'b1;
		item       <= '{f, c};
		typed_on   <= tv;
		typed_want <= tw;
		do @(posedge clk); while (busy);
	endtask

	task automatic send_char(input logic [7:0] c);
		send(FUNC_CHAR, c, 1'b0, '0);
	endtask

	// Letters of a word (vocabulary or random), then one or two separators
	task automatic send_word(input int n, input int src, inout int count);
		int k;
		for (k = 0; k < n; k++)
			send_char((src >= 0 && k < vocab_len[src]) ? vocab[src][k] : any_letter());
		send_char(any_separator());
		count += n + 1;
		if ($urandom_range(0, 3) == 0) begin
			send_char(any_separator());
			count++;
		end
	endtask

	// Check results and predict each accepted transfer
	always @(posedge clk) begin
		bit      took, made;
		result_t pred, want;
		took = start && !busy;
		if (arst_n) begin
			if (done) begin
				case (result.status)
					ST_MATCH:  n_match++;
					ST_INSERT: n_insert++;
					default:   n_full++;
				endcase
				if (expected_words.size() == 0) begin
					flag_mismatch($sformatf("result with no word pending: %0d/%0d/%0d/%0d",
						result.status, result.slot, result.word_count, result.word_length));
				end else begin
					want = expected_words.pop_front();
					if (result.status !== want.status)
						flag_mismatch($sformatf("status got %0d expected %0d",
							result.status, want.status));
					if (result.slot !== want.slot)
						flag_mismatch($sformatf("slot got %0d expected %0d",
							result.slot, want.slot));
					if (result.word_count !== want.word_count)
						flag_mismatch($sformatf("word_count got %0d expected %0d",
							result.word_count, want.word_count));
					if (result.word_length !== want.word_length)
						flag_mismatch($sformatf("word_length got %0d expected %0d",
							result.word_length, want.word_length));
				end
			end
			if (took) begin
				chars_taken++;
				word_table_step(item, made, pred);
				if (made)
					expected_words.push_back(typed_on ? typed_want : pred);
			end
			// watchdog: no transfer either way for too long
			if (took || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("watchdog expired with %0d words pending", expected_words.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int r, i, n, sent;
		clk         = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;
		typed_on    = 1'b0;
		typed_want  = '0;
		tbl_used    = 0;
		word_len    = 0;
		err_cnt     = 0;
		idle_cycles = 0;
		chars_taken = 0;
		n_match     = 0;
		n_insert    = 0;
		n_full      = 0;
		gaps_on     = 1'b1;
		for (i = 0; i < 24; i++) begin
			vocab_len[i] = ($urandom_range(0, 5) == 0) ? WORD_MAX : $urandom_range(1, 6);
			for (n = 0; n < WORD_MAX; n++)
				vocab[i][n] = any_letter();
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: extremes, case, empty tokens, full word, clear
		for (i = 0; i < 21; i++)
			for (n = 0; n < dir_rows[i].reps; n++)
				send(dir_rows[i].func, dir_rows[i].ch,
					(n == dir_rows[i].reps - 1) ? dir_rows[i].typed : 1'b0,
					dir_rows[i].want);

		// fill the table past its end, then hit a stored word
		send(FUNC_CLEAR, 8'h00, 1'b0, '0);
		for (i = 0; i < N_ENTRIES + 3; i++) begin
			send_char(8'(8'h41 + i % 26));
			send_char(8'(8'h61 + i / 26));
			send_char(8'h20);
		end
		send_char(8'h41);
		send_char(8'h61);
		send_char(8'h0A);

		// random text: mostly words, some noise and the odd clear
		send(FUNC_CLEAR, 8'h00, 1'b0, '0);
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 50 < 8)
				gaps_on = ($urandom_range(0, 3) != 0);
			if (sent > RANDOM_ITEMS - 150)
				gaps_on = 1'b0;
			r = $urandom_range(0, 99);
			if (r < 2) begin
				send(FUNC_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '0);
				sent++;
			end else if (r < 60) begin
				n = $urandom_range(0, 23);
				send_word(vocab_len[n], n, sent);
			end else if (r < 80) begin
				send_word($urandom_range(1, 8), -1, sent);
			end else if (r < 86) begin
				send_word(WORD_MAX, -1, sent);
			end else if (r < 92) begin
				// runs past the word limit: the first extra letter ends the word and is lost, the rest start a new word
				send_word($urandom_range(WORD_MAX + 1, WORD_MAX + 6), -1, sent);
			end else begin
				n = $urandom_range(1, 3);
				repeat (n)
					send_char(8'($urandom_range(0, 255)));
				sent += n;
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_words.size() != 0)
			flag_mismatch($sformatf("%0d words never reported", expected_words.size()));

		$display("Ran %0d transfers: %0d matches, %0d inserts, %0d dropped on a full table.",
			chars_taken, n_match, n_insert, n_full);
		$display("Covered directed edge cases, a table overflow and random text with idle gaps.");
		if (err_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
